[rtl/epsd_pkg.sv]
// Shared constants, types and the month-length function for the seconds-to-date converter.
`default_nettype none

package epsd_pkg;

  localparam int unsigned EPOCH_W   = 32;
  localparam int unsigned YEAR_W    = 12;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned DAY_W     = 5;
  localparam int unsigned HOURS_W   = 5;
  localparam int unsigned MINUTES_W = 6;
  localparam int unsigned SECS_W    = 6;

  // day count since the base date never exceeds 49710
  localparam int unsigned DAY_CNT_W = 16;
  localparam int unsigned YOFF_W    = 8;
  localparam int unsigned LEN_W     = 13;

  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;

  localparam logic [YEAR_W-1:0] BASE_YEAR = 12'd2000;

  // 16-year and 4-year blocks hold 4 and 1 leap days; the block that holds
  // 2100 is one day short
  localparam logic [LEN_W-1:0] Y16_DAYS    = 13'd5844;
  localparam logic [LEN_W-1:0] Y4_DAYS     = 13'd1461;
  localparam logic [LEN_W-1:0] Y1_DAYS     = 13'd365;
  localparam logic [YOFF_W-1:0] GRP16_CENT = 8'd96;
  localparam logic [YOFF_W-1:0] CENT_OFF   = 8'd100;

  // zero-based month codes
  localparam logic [MONTH_W-1:0] MON_JAN = 4'd0;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd1;
  localparam logic [MONTH_W-1:0] MON_APR = 4'd3;
  localparam logic [MONTH_W-1:0] MON_JUN = 4'd5;
  localparam logic [MONTH_W-1:0] MON_SEP = 4'd8;
  localparam logic [MONTH_W-1:0] MON_NOV = 4'd10;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } epsd_date_t;

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    len = 5'd31;
    case (m) inside
      MON_FEB: len = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

[rtl/epsd_chan_if.sv]
// Valid/ready channel interfaces for the converter's request and result sides.
`default_nettype none

interface epsd_in_if;
  import epsd_pkg::*;

  logic               valid;
  logic               ready;
  logic [EPOCH_W-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface epsd_out_if;
  import epsd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [YEAR_W-1:0]    year;
  logic [MONTH_W-1:0]   month;
  logic [DAY_W-1:0]     day;
  logic [HOURS_W-1:0]   hours;
  logic [MINUTES_W-1:0] minutes;
  logic [SECS_W-1:0]    secs;

  modport source (output valid, output year, output month, output day,
                  output hours, output minutes, output secs, input ready);
  modport sink   (input valid, input year, input month, input day,
                  input hours, input minutes, input secs, output ready);
endinterface

`default_nettype wire

[rtl/epoch_seconds_to_date_time_core.sv]
// Top level of the seconds-to-Gregorian date and time converter.
// Converts an unsigned 32-bit count of seconds since 2000-01-01 00:00:00 into
// year, month, day, hour, minute and second. One request is worked on at a
// time, and the next request is accepted once the result has been loaded into
// the output register. The time goes to three bit-serial dividers in a row:
// one splits off whole days (a load, then a step for each of 32 bits), one the
// hours (a load, then 17 bit steps) and one the minutes and seconds (a load,
// then 12 bit steps). The control then moves to its final state and loads the
// output register. The calendar walk runs beside the hour and minute dividers
// and never adds time. A finished result sits in the output register; the next
// request is taken while it waits, and its result is held back until the
// previous one is taken. No configuration and no state is kept between
// requests.
`default_nettype none

module epoch_seconds_to_date_time_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  epsd_in_if.sink     in_chan,
  epsd_out_if.source  out_chan
);
  import epsd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DAY  = 3'd1;
  localparam logic [2:0] S_TOD  = 3'd2;
  localparam logic [2:0] S_MIN  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam int unsigned DRW = $clog2(SECS_PER_DAY);
  localparam int unsigned HRW = $clog2(SECS_PER_HOUR);
  localparam int unsigned MRW = $clog2(SECS_PER_MIN);

  logic [2:0]           state_r;
  logic                 cal_fin_r;
  logic [HOURS_W-1:0]   hours_r;
  logic                 out_valid_r;
  epsd_date_t           out_date_r;
  logic [HOURS_W-1:0]   out_hours_r;
  logic [MINUTES_W-1:0] out_minutes_r;
  logic [SECS_W-1:0]    out_secs_r;

  logic               in_ready;
  logic               in_acc;
  logic               out_load;

  logic               day_done;
  logic [EPOCH_W-1:0] day_quo;
  logic [DRW-1:0]     day_rem;
  logic               tod_done;
  logic [DRW-1:0]     tod_quo;
  logic [HRW-1:0]     tod_rem;
  logic               min_done;
  logic [HRW-1:0]     min_quo;
  logic [MRW-1:0]     min_rem;
  logic               cal_done;
  epsd_date_t         cal_date;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_chan.valid && in_ready;
  assign out_load = (state_r == S_FIN) && cal_fin_r && (!out_valid_r || out_chan.ready);

  epsd_sdiv #(.NW(EPOCH_W), .DIVISOR(SECS_PER_DAY)) u_day_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .dividend (in_chan.epoch_seconds),
    .done     (day_done),
    .quo      (day_quo),
    .rem      (day_rem)
  );

  epsd_sdiv #(.NW(DRW), .DIVISOR(SECS_PER_HOUR)) u_tod_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (day_done),
    .dividend (day_rem),
    .done     (tod_done),
    .quo      (tod_quo),
    .rem      (tod_rem)
  );

  epsd_sdiv #(.NW(HRW), .DIVISOR(SECS_PER_MIN)) u_min_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (tod_done),
    .dividend (tod_rem),
    .done     (min_done),
    .quo      (min_quo),
    .rem      (min_rem)
  );

  epsd_cal u_cal (
    .clk   (clk),
    .rst_n (rst_n),
    .start (day_done),
    .days  (day_quo[DAY_CNT_W-1:0]),
    .done  (cal_done),
    .date  (cal_date)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cal_fin_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
        cal_fin_r   <= 1'b0;
      end else begin
        if (out_valid_r && out_chan.ready) begin
          out_valid_r <= 1'b0;
        end
        if (cal_done) begin
          cal_fin_r <= 1'b1;
        end
      end
      case (state_r)
        S_IDLE: if (in_acc) state_r <= S_DAY;
        S_DAY:  if (day_done) state_r <= S_TOD;
        S_TOD: begin
          if (tod_done) begin
            hours_r <= tod_quo[HOURS_W-1:0];
            state_r <= S_MIN;
          end
        end
        S_MIN:  if (min_done) state_r <= S_FIN;
        S_FIN: begin
          if (out_load) begin
            out_date_r    <= cal_date;
            out_hours_r   <= hours_r;
            out_minutes_r <= min_quo[MINUTES_W-1:0];
            out_secs_r    <= min_rem[SECS_W-1:0];
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_chan.ready    = in_ready;
  assign out_chan.valid   = out_valid_r;
  assign out_chan.year    = out_date_r.year;
  assign out_chan.month   = out_date_r.month;
  assign out_chan.day     = out_date_r.day;
  assign out_chan.hours   = out_hours_r;
  assign out_chan.minutes = out_minutes_r;
  assign out_chan.secs    = out_secs_r;

  // the day divider only finishes for the request currently in its first phase
  a_day_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    day_done |-> state_r == S_DAY)
    else $error("day divider finished outside the day phase");

  // time-of-day split must leave a valid hour by the time minutes are ready
  a_hours_range: assert property (@(posedge clk) disable iff (!rst_n)
    min_done |-> hours_r < 5'd24)
    else $error("hour out of range");

  // a loaded result always carries a real month and day
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_date_r.month >= 4'd1) && (out_date_r.month <= 4'd12)
                 && (out_date_r.day != 5'd0))
    else $error("calendar walk produced an invalid date");

endmodule

`default_nettype wire

[rtl/epsd_sdiv.sv]
// Bit-serial restoring divider by a constant: one quotient bit per cycle.
`default_nettype none

module epsd_sdiv #(
  parameter int unsigned NW      = 32,
  parameter int unsigned DIVISOR = 86400
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [NW-1:0]               dividend,
  output logic                             done,
  output logic [NW-1:0]                    quo,
  output logic [$clog2(DIVISOR)-1:0]       rem
);
  localparam int unsigned RW = $clog2(DIVISOR);
  localparam int unsigned CW = $clog2(NW + 1);
  localparam logic [RW:0] DIV_C  = (RW+1)'(DIVISOR);
  localparam logic [CW-1:0] LAST = CW'(NW - 1);

  logic [NW-1:0] q_r;
  logic [RW-1:0] r_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic          ge;
  logic [RW-1:0] r_nxt;

  always_comb begin
    trial = {r_r, q_r[NW-1]};
    ge    = trial >= DIV_C;
    diff  = trial - DIV_C;
    r_nxt = ge ? diff[RW-1:0] : trial[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= dividend;
        r_r    <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        q_r   <= {q_r[NW-2:0], ge};
        r_r   <= r_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = r_r;

endmodule

`default_nettype wire

[rtl/epsd_cal.sv]
// Calendar walk: peels 16-year, 4-year, single-year and month spans off a day count.
`default_nettype none

module epsd_cal (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [epsd_pkg::DAY_CNT_W-1:0]    days,
  output logic                                   done,
  output epsd_pkg::epsd_date_t                   date
);
  import epsd_pkg::*;

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_Y16  = 3'd1;
  localparam logic [2:0] P_Y4   = 3'd2;
  localparam logic [2:0] P_Y1   = 3'd3;
  localparam logic [2:0] P_MON  = 3'd4;

  logic [2:0]           phase_r;
  logic                 done_r;
  logic [DAY_CNT_W-1:0] days_r;
  logic [YOFF_W-1:0]    yoff_r;
  logic [MONTH_W-1:0]   mon_r;

  logic                 leap;
  logic [LEN_W-1:0]     len;
  logic [YOFF_W-1:0]    ystep;
  logic                 ge;
  logic [DAY_CNT_W-1:0] diff;

  always_comb begin
    // 2000 is a leap year, 2100 is not; nothing else in range is a century
    leap  = (yoff_r[1:0] == 2'b00) && (yoff_r != CENT_OFF);
    len   = Y1_DAYS;
    ystep = 8'd1;
    case (phase_r)
      P_Y16: begin
        len   = (yoff_r == GRP16_CENT) ? Y16_DAYS - 1'b1 : Y16_DAYS;
        ystep = 8'd16;
      end
      P_Y4: begin
        len   = (yoff_r == CENT_OFF) ? Y4_DAYS - 1'b1 : Y4_DAYS;
        ystep = 8'd4;
      end
      P_Y1: begin
        len   = leap ? Y1_DAYS + 1'b1 : Y1_DAYS;
        ystep = 8'd1;
      end
      P_MON: begin
        len   = {{(LEN_W-DAY_W){1'b0}}, month_days(mon_r, leap)};
        ystep = 8'd0;
      end
      default: begin
        len   = Y1_DAYS;
        ystep = 8'd0;
      end
    endcase
    ge   = days_r >= {{(DAY_CNT_W-LEN_W){1'b0}}, len};
    diff = days_r - {{(DAY_CNT_W-LEN_W){1'b0}}, len};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (phase_r)
        P_IDLE: begin
          if (start) begin
            days_r  <= days;
            yoff_r  <= '0;
            mon_r   <= MON_JAN;
            phase_r <= P_Y16;
          end
        end
        P_Y16, P_Y4, P_Y1: begin
          if (ge) begin
            days_r <= diff;
            yoff_r <= yoff_r + ystep;
          end else begin
            phase_r <= phase_r + 1'b1;
          end
        end
        P_MON: begin
          if (ge) begin
            days_r <= diff;
            mon_r  <= mon_r + 1'b1;
          end
          // December is never tested: whatever is left lies in it
          if (!ge || mon_r == MON_NOV) begin
            phase_r <= P_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: phase_r <= P_IDLE;
      endcase
    end
  end

  assign done       = done_r;
  assign date.year  = BASE_YEAR + {{(YEAR_W-YOFF_W){1'b0}}, yoff_r};
  assign date.month = mon_r + 1'b1;
  assign date.day   = days_r[DAY_W-1:0] + 1'b1;

endmodule

`default_nettype wire
